### rtl/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Types, token codes, character constants and lookup functions used by the
// token scanner.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int unsigned WORD_STORE        = 9;
  localparam int unsigned WORD_IDX_W        = $clog2(WORD_STORE);
  localparam int unsigned NAME_PREFIX_CHARS = 8;
  localparam int unsigned KW_COUNT          = 22;

  typedef enum logic [2:0] {
    M_IDLE,
    M_WORD,
    M_NUM,
    M_COLON,
    M_LESS,
    M_GREATER,
    M_DOT,
    M_COMMENT
  } scan_mode_t;

  // token codes
  localparam logic [5:0] TK_IDENT      = 6'd0;
  localparam logic [5:0] TK_NUMBER     = 6'd1;
  localparam logic [5:0] TK_PLUS       = 6'd2;
  localparam logic [5:0] TK_MINUS      = 6'd3;
  localparam logic [5:0] TK_TIMES      = 6'd4;
  localparam logic [5:0] TK_DIVIDE     = 6'd5;
  localparam logic [5:0] TK_AND        = 6'd6;
  localparam logic [5:0] TK_OR         = 6'd7;
  localparam logic [5:0] TK_MOD        = 6'd8;
  localparam logic [5:0] TK_DIV        = 6'd9;
  localparam logic [5:0] TK_EQUAL      = 6'd10;
  localparam logic [5:0] TK_NOTEQUAL   = 6'd11;
  localparam logic [5:0] TK_LESS       = 6'd12;
  localparam logic [5:0] TK_GREATER    = 6'd13;
  localparam logic [5:0] TK_LESSEQ     = 6'd14;
  localparam logic [5:0] TK_GREATEREQ  = 6'd15;
  localparam logic [5:0] TK_LPAREN     = 6'd16;
  localparam logic [5:0] TK_RPAREN     = 6'd17;
  localparam logic [5:0] TK_LBRACKET   = 6'd18;
  localparam logic [5:0] TK_RBRACKET   = 6'd19;
  localparam logic [5:0] TK_ASSIGN     = 6'd20;
  localparam logic [5:0] TK_COMMA      = 6'd21;
  localparam logic [5:0] TK_COLON      = 6'd22;
  localparam logic [5:0] TK_SEMICOLON  = 6'd23;
  localparam logic [5:0] TK_DOTDOT     = 6'd24;
  localparam logic [5:0] TK_DOT        = 6'd25;
  localparam logic [5:0] TK_VAR        = 6'd26;
  localparam logic [5:0] TK_CONST      = 6'd27;
  localparam logic [5:0] TK_IF         = 6'd28;
  localparam logic [5:0] TK_THEN       = 6'd29;
  localparam logic [5:0] TK_ELSE       = 6'd30;
  localparam logic [5:0] TK_BEGIN      = 6'd31;
  localparam logic [5:0] TK_END        = 6'd32;
  localparam logic [5:0] TK_WHILE      = 6'd33;
  localparam logic [5:0] TK_DO         = 6'd34;
  localparam logic [5:0] TK_TO         = 6'd38;
  localparam logic [5:0] TK_DOWNTO     = 6'd39;
  localparam logic [5:0] TK_PROGRAM    = 6'd40;
  localparam logic [5:0] TK_PROCEDURE  = 6'd41;
  localparam logic [5:0] TK_FUNCTION   = 6'd42;
  localparam logic [5:0] TK_FORWARD    = 6'd43;
  localparam logic [5:0] TK_ARRAY      = 6'd44;
  localparam logic [5:0] TK_INTEGER    = 6'd45;
  localparam logic [5:0] TK_OF         = 6'd46;
  localparam logic [5:0] TK_EOI        = 6'd47;
  localparam logic [5:0] TK_ERR        = 6'd48;

  // error kinds
  localparam logic [1:0] ERR_NONE          = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED    = 2'd1;
  localparam logic [1:0] ERR_LETTER_IN_NUM = 2'd2;
  localparam logic [1:0] ERR_OPEN_COMMENT  = 2'd3;

  // characters
  localparam logic [7:0] CH_LBRACE   = "{";
  localparam logic [7:0] CH_RBRACE   = "}";
  localparam logic [7:0] CH_ZERO     = "0";
  localparam logic [7:0] CH_NINE     = "9";
  localparam logic [7:0] CH_SPACE    = " ";
  localparam logic [7:0] CH_DOT      = ".";
  localparam logic [7:0] CH_COLON    = ":";
  localparam logic [7:0] CH_LT       = "<";
  localparam logic [7:0] CH_GT       = ">";
  localparam logic [7:0] CH_EQ       = "=";
  localparam logic [7:0] CH_SEMI     = ";";
  localparam logic [7:0] CH_COMMA    = ",";
  localparam logic [7:0] CH_PLUS     = "+";
  localparam logic [7:0] CH_MINUS    = "-";
  localparam logic [7:0] CH_STAR     = "*";
  localparam logic [7:0] CH_SLASH    = "/";
  localparam logic [7:0] CH_LPAREN   = "(";
  localparam logic [7:0] CH_RPAREN   = ")";
  localparam logic [7:0] CH_LBRACKET = "[";
  localparam logic [7:0] CH_RBRACKET = "]";
  localparam logic [7:0] CH_UPPER_A  = "A";
  localparam logic [7:0] CH_UPPER_Z  = "Z";
  localparam logic [7:0] CH_LOWER_A  = "a";
  localparam logic [7:0] CH_LOWER_Z  = "z";

  // keyword text is right-justified: the last character sits in the low byte
  localparam logic [8*WORD_STORE-1:0] KW_TEXT [KW_COUNT] = '{
    "var", "integer", "array", "program", "procedure", "function",
    "forward", "AND", "OR", "const", "begin", "end", "downto", "to",
    "of", "if", "then", "else", "while", "do", "mod", "div"
  };
  localparam int unsigned KW_LEN [KW_COUNT] = '{
    3, 7, 5, 7, 9, 8, 7, 3, 2, 5, 5, 3, 6, 2, 2, 2, 4, 4, 5, 2, 3, 3
  };
  localparam logic [5:0] KW_CODE [KW_COUNT] = '{
    TK_VAR, TK_INTEGER, TK_ARRAY, TK_PROGRAM, TK_PROCEDURE, TK_FUNCTION,
    TK_FORWARD, TK_AND, TK_OR, TK_CONST, TK_BEGIN, TK_END, TK_DOWNTO, TK_TO,
    TK_OF, TK_IF, TK_THEN, TK_ELSE, TK_WHILE, TK_DO, TK_MOD, TK_DIV
  };

  typedef logic [WORD_STORE-1:0][7:0] word_buf_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [31:0] num;
    logic [63:0] prefix;
    logic [7:0]  len;
  } token_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] code;
  } code_hit_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic token_t make_tok(input logic [5:0] kind, input logic [1:0] err);
    token_t t;
    t      = '0;
    t.kind = kind;
    t.err  = err;
    return t;
  endfunction

  function automatic code_hit_t single_lookup(input logic [7:0] c);
    code_hit_t r;
    r = '0;
    case (c)
      CH_SEMI:     r = '{1'b1, TK_SEMICOLON};
      CH_COMMA:    r = '{1'b1, TK_COMMA};
      CH_PLUS:     r = '{1'b1, TK_PLUS};
      CH_MINUS:    r = '{1'b1, TK_MINUS};
      CH_STAR:     r = '{1'b1, TK_TIMES};
      CH_SLASH:    r = '{1'b1, TK_DIVIDE};
      CH_EQ:       r = '{1'b1, TK_EQUAL};
      CH_LPAREN:   r = '{1'b1, TK_LPAREN};
      CH_RPAREN:   r = '{1'b1, TK_RPAREN};
      CH_LBRACKET: r = '{1'b1, TK_LBRACKET};
      CH_RBRACKET: r = '{1'b1, TK_RBRACKET};
      default:     r = '0;
    endcase
    return r;
  endfunction

  // parallel compare against every keyword; only bytes below len are looked at
  function automatic code_hit_t kw_lookup(input word_buf_t chars, input logic [7:0] len);
    code_hit_t r;
    logic      m;
    r = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      m = (len == 8'(KW_LEN[i]));
      for (int j = 0; j < WORD_STORE; j++) begin
        if (j < KW_LEN[i]) begin
          if (chars[j] != KW_TEXT[i][8*(KW_LEN[i]-1-j) +: 8]) m = 1'b0;
        end
      end
      if (m && !r.hit) r = '{1'b1, KW_CODE[i]};
    end
    return r;
  endfunction

  function automatic logic [63:0] name_prefix_of(input word_buf_t chars, input logic [7:0] len);
    logic [63:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < len && i < NAME_PREFIX_CHARS) p[8*i +: 8] = chars[i];
    end
    return p;
  endfunction

endpackage

### rtl/pst_in_if.sv
// ----------------------------------------------------------------------------
// pst_in_if
// Character channel into the token scanner: valid/ready plus one character
// and the end-of-text flag per item.
// ----------------------------------------------------------------------------
interface pst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

### rtl/pst_out_if.sv
// ----------------------------------------------------------------------------
// pst_out_if
// Token channel out of the token scanner: valid/ready plus one token per item.
// ----------------------------------------------------------------------------
interface pst_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [1:0]  error_kind;
  logic [31:0] number_value;
  logic [63:0] name_prefix;
  logic [7:0]  name_length;
  logic        last;

  modport source (output valid, output token_kind, output error_kind, output number_value,
                  output name_prefix, output name_length, output last, input ready);
  modport sink   (input valid, input token_kind, input error_kind, input number_value,
                  input name_prefix, input name_length, input last, output ready);
endinterface

### rtl/pascal_subset_token_scanner_core.sv
// ----------------------------------------------------------------------------
// pascal_subset_token_scanner_core
// Character-at-a-time scanner for a small Pascal-like language.
// Timing: a character registers at acceptance; when that stage advances, its
// tokens enter the result queue, whose head drives out_item directly.
// Throughput: one character per cycle while the 4-entry result queue holds no
// more than two tokens; a character giving two tokens fills two entries.
// Reset (rst_n low, synchronous): scanner idle, counters cleared, queue empty.
// ----------------------------------------------------------------------------
module pascal_subset_token_scanner_core #(
  parameter int unsigned MAX_COMMENT_DEPTH = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  pst_in_if.sink     in_item,
  pst_out_if.source  out_item
);

  localparam int unsigned DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_eoi_r;

  // scanner state
  pst_pkg::scan_mode_t  mode_r, mode_nxt;
  pst_pkg::word_buf_t   word_r, word_nxt;
  logic [7:0]           wlen_r, wlen_nxt;
  logic [31:0]          acc_r, acc_nxt;
  logic [DEPTH_W-1:0]   depth_r, depth_nxt;

  // result queue
  pst_pkg::token_t      q_tok_r [Q_DEPTH];
  logic                 q_last_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   q_wr_r, q_rd_r;
  logic [Q_CNT_W-1:0]   q_cnt_r;

  logic                 s1_go, in_acc, pop;
  logic                 c_letter, c_digit, c_ws, restart, idle_emit;
  pst_pkg::scan_mode_t  idle_mode;
  pst_pkg::code_hit_t   single, kw;
  logic [63:0]          prefix;
  pst_pkg::token_t      pend_tok, idle_tok, a_tok, b_tok, res0, res1;
  logic                 pend_v, a_v, b_v, res0_v, res1_v;
  logic [1:0]           push_n;
  logic [31:0]          digit_val;

  assign s1_go         = s1_valid_r && (q_cnt_r <= Q_CNT_W'(Q_DEPTH - 2));
  assign in_item.ready = !s1_valid_r || s1_go;
  assign in_acc        = in_item.valid && in_item.ready;
  assign pop           = out_item.valid && out_item.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_item.ready) begin
      s1_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r  <= in_item.ch;
      s1_eoi_r <= in_item.end_of_input;
    end
  end

  // character decode
  assign c_letter  = pst_pkg::is_letter(s1_ch_r);
  assign c_digit   = pst_pkg::is_digit(s1_ch_r);
  assign c_ws      = (s1_ch_r <= pst_pkg::CH_SPACE) || s1_ch_r[7];
  assign single    = pst_pkg::single_lookup(s1_ch_r);
  assign kw        = pst_pkg::kw_lookup(word_r, wlen_r);
  assign prefix    = pst_pkg::name_prefix_of(word_r, wlen_r);
  assign digit_val = 32'(s1_ch_r - pst_pkg::CH_ZERO);

  // what a character does when seen with nothing pending
  always_comb begin
    priority if (c_ws)                       idle_mode = pst_pkg::M_IDLE;
    else if (c_letter)                       idle_mode = pst_pkg::M_WORD;
    else if (c_digit)                        idle_mode = pst_pkg::M_NUM;
    else if (s1_ch_r == pst_pkg::CH_LBRACE)  idle_mode = pst_pkg::M_COMMENT;
    else if (s1_ch_r == pst_pkg::CH_COLON)   idle_mode = pst_pkg::M_COLON;
    else if (s1_ch_r == pst_pkg::CH_LT)      idle_mode = pst_pkg::M_LESS;
    else if (s1_ch_r == pst_pkg::CH_GT)      idle_mode = pst_pkg::M_GREATER;
    else if (s1_ch_r == pst_pkg::CH_DOT)     idle_mode = pst_pkg::M_DOT;
    else                                     idle_mode = pst_pkg::M_IDLE;
  end

  assign idle_emit = !c_ws && (idle_mode == pst_pkg::M_IDLE);
  assign idle_tok  = single.hit ? pst_pkg::make_tok(single.code, pst_pkg::ERR_NONE)
                                : pst_pkg::make_tok(pst_pkg::TK_ERR, pst_pkg::ERR_UNEXPECTED);

  // pending token flushed by a terminating character
  always_comb begin
    pend_tok = '0;
    pend_v   = 1'b1;
    unique case (mode_r)
      pst_pkg::M_WORD: begin
        if (kw.hit) begin
          pend_tok = pst_pkg::make_tok(kw.code, pst_pkg::ERR_NONE);
        end else begin
          pend_tok        = pst_pkg::make_tok(pst_pkg::TK_IDENT, pst_pkg::ERR_NONE);
          pend_tok.prefix = prefix;
          pend_tok.len    = wlen_r;
        end
      end
      pst_pkg::M_NUM: begin
        pend_tok     = pst_pkg::make_tok(pst_pkg::TK_NUMBER, pst_pkg::ERR_NONE);
        pend_tok.num = acc_r;
      end
      pst_pkg::M_COLON:   pend_tok = pst_pkg::make_tok(pst_pkg::TK_COLON, pst_pkg::ERR_NONE);
      pst_pkg::M_LESS:    pend_tok = pst_pkg::make_tok(pst_pkg::TK_LESS, pst_pkg::ERR_NONE);
      pst_pkg::M_GREATER: pend_tok = pst_pkg::make_tok(pst_pkg::TK_GREATER, pst_pkg::ERR_NONE);
      pst_pkg::M_DOT:     pend_tok = pst_pkg::make_tok(pst_pkg::TK_DOT, pst_pkg::ERR_NONE);
      pst_pkg::M_IDLE,
      pst_pkg::M_COMMENT: pend_v   = 1'b0;
      default:            pend_v   = 1'b0;
    endcase
  end

  // the current character ends the pending token and is rescanned from idle
  always_comb begin
    unique case (mode_r)
      pst_pkg::M_IDLE:    restart = 1'b1;
      pst_pkg::M_WORD:    restart = !(c_letter || c_digit);
      pst_pkg::M_NUM:     restart = !(c_letter || c_digit);
      pst_pkg::M_COLON,
      pst_pkg::M_GREATER: restart = (s1_ch_r != pst_pkg::CH_EQ);
      pst_pkg::M_DOT:     restart = (s1_ch_r != pst_pkg::CH_DOT);
      pst_pkg::M_LESS:    restart = (s1_ch_r != pst_pkg::CH_EQ) && (s1_ch_r != pst_pkg::CH_GT);
      pst_pkg::M_COMMENT: restart = 1'b0;
      default:            restart = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    if (s1_eoi_r) begin
      mode_nxt = pst_pkg::M_IDLE;
    end else if (restart) begin
      mode_nxt = idle_mode;
    end else begin
      unique case (mode_r)
        pst_pkg::M_WORD:    mode_nxt = pst_pkg::M_WORD;
        pst_pkg::M_NUM:     mode_nxt = c_letter ? pst_pkg::M_WORD : pst_pkg::M_NUM;
        pst_pkg::M_COMMENT: begin
          if (s1_ch_r == pst_pkg::CH_RBRACE && depth_r <= DEPTH_W'(1)) begin
            mode_nxt = pst_pkg::M_IDLE;
          end
        end
        default:            mode_nxt = pst_pkg::M_IDLE;
      endcase
    end
  end

  // tokens
  always_comb begin
    a_tok = '0;
    a_v   = 1'b0;
    b_tok = '0;
    b_v   = 1'b0;
    if (s1_eoi_r) begin
      if (mode_r == pst_pkg::M_COMMENT) begin
        a_tok = pst_pkg::make_tok(pst_pkg::TK_ERR, pst_pkg::ERR_OPEN_COMMENT);
        a_v   = 1'b1;
      end else begin
        a_tok = pend_tok;
        a_v   = pend_v;
      end
      b_tok = pst_pkg::make_tok(pst_pkg::TK_EOI, pst_pkg::ERR_NONE);
      b_v   = 1'b1;
    end else if (restart) begin
      a_tok = pend_tok;
      a_v   = pend_v;
      b_tok = idle_tok;
      b_v   = idle_emit;
    end else begin
      a_v = 1'b1;
      unique case (mode_r)
        pst_pkg::M_NUM: begin
          a_tok = pst_pkg::make_tok(pst_pkg::TK_ERR, pst_pkg::ERR_LETTER_IN_NUM);
          a_v   = c_letter;
        end
        pst_pkg::M_COLON:   a_tok = pst_pkg::make_tok(pst_pkg::TK_ASSIGN, pst_pkg::ERR_NONE);
        pst_pkg::M_GREATER: a_tok = pst_pkg::make_tok(pst_pkg::TK_GREATEREQ, pst_pkg::ERR_NONE);
        pst_pkg::M_DOT:     a_tok = pst_pkg::make_tok(pst_pkg::TK_DOTDOT, pst_pkg::ERR_NONE);
        pst_pkg::M_LESS: begin
          a_tok = (s1_ch_r == pst_pkg::CH_GT)
                  ? pst_pkg::make_tok(pst_pkg::TK_NOTEQUAL, pst_pkg::ERR_NONE)
                  : pst_pkg::make_tok(pst_pkg::TK_LESSEQ, pst_pkg::ERR_NONE);
        end
        default:            a_v   = 1'b0;
      endcase
    end
    res0   = a_v ? a_tok : b_tok;
    res0_v = a_v || b_v;
    res1   = b_tok;
    res1_v = a_v && b_v;
    push_n = s1_go ? {res1_v, res0_v && !res1_v} : 2'd0;
  end

  // word, number and comment datapath
  always_comb begin
    word_nxt  = word_r;
    wlen_nxt  = wlen_r;
    acc_nxt   = acc_r;
    depth_nxt = depth_r;
    if (s1_eoi_r) begin
      wlen_nxt  = '0;
      acc_nxt   = '0;
      depth_nxt = '0;
    end else if (restart) begin
      if (c_letter) begin
        word_nxt[0] = s1_ch_r;
        wlen_nxt    = 8'd1;
      end else if (c_digit) begin
        acc_nxt = digit_val;
      end else if (s1_ch_r == pst_pkg::CH_LBRACE) begin
        depth_nxt = DEPTH_W'(1);
      end
    end else begin
      unique case (mode_r)
        pst_pkg::M_WORD: begin
          if (wlen_r < 8'(pst_pkg::WORD_STORE)) begin
            word_nxt[wlen_r[pst_pkg::WORD_IDX_W-1:0]] = s1_ch_r;
          end
          if (wlen_r != 8'hFF) wlen_nxt = wlen_r + 8'd1;
        end
        pst_pkg::M_NUM: begin
          if (c_digit) begin
            acc_nxt = (acc_r << 3) + (acc_r << 1) + digit_val;
          end else begin
            word_nxt[0] = s1_ch_r;
            wlen_nxt    = 8'd1;
          end
        end
        pst_pkg::M_COMMENT: begin
          if (s1_ch_r == pst_pkg::CH_LBRACE) begin
            if (depth_r < DEPTH_W'(MAX_COMMENT_DEPTH)) depth_nxt = depth_r + DEPTH_W'(1);
          end else if (s1_ch_r == pst_pkg::CH_RBRACE) begin
            if (depth_r != '0) depth_nxt = depth_r - DEPTH_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= pst_pkg::M_IDLE;
      wlen_r  <= '0;
      acc_r   <= '0;
      depth_r <= '0;
    end else if (s1_go) begin
      mode_r  <= mode_nxt;
      wlen_r  <= wlen_nxt;
      acc_r   <= acc_nxt;
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) word_r <= word_nxt;
  end

  // result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_wr_r  <= q_wr_r + Q_PTR_W'(push_n);
      q_rd_r  <= q_rd_r + Q_PTR_W'(pop);
      q_cnt_r <= q_cnt_r + Q_CNT_W'(push_n) - Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      if (s1_go && res0_v && (q_wr_r == Q_PTR_W'(i))) begin
        q_tok_r[i]  <= res0;
        q_last_r[i] <= !res1_v;
      end else if (s1_go && res1_v && (q_wr_r + Q_PTR_W'(1) == Q_PTR_W'(i))) begin
        q_tok_r[i]  <= res1;
        q_last_r[i] <= 1'b1;
      end
    end
  end

  assign out_item.valid        = (q_cnt_r != '0);
  assign out_item.token_kind   = q_tok_r[q_rd_r].kind;
  assign out_item.error_kind   = q_tok_r[q_rd_r].err;
  assign out_item.number_value = q_tok_r[q_rd_r].num;
  assign out_item.name_prefix  = q_tok_r[q_rd_r].prefix;
  assign out_item.name_length  = q_tok_r[q_rd_r].len;
  assign out_item.last         = q_last_r[q_rd_r];

  // checks
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  a_comment_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == pst_pkg::M_COMMENT) == (depth_r != '0))
    else $error("comment depth out of step with scan mode");

  a_eoi_tokens: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_eoi_r) |-> (push_n != 2'd0) && (b_tok.kind == pst_pkg::TK_EOI))
    else $error("end of text without end token");

  a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_eoi_r) |=> (mode_r == pst_pkg::M_IDLE) && (wlen_r == '0) && (acc_r == '0))
    else $error("scanner state not cleared after end of text");

endmodule
